// ----- rtl/binary_to_decimal_digits_unit_macros.svh -----
// Assertion macros used by the checker of the digit unit.
`ifndef BINARY_TO_DECIMAL_DIGITS_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_DIGITS_UNIT_MACROS_SVH

// Overlapping implication, checked at every rising clock edge.
`define B2D_ASSERT_NOW(lbl, clk, off, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (off) (ante) |-> (cons)) \
        else $error("b2d check failed");

// Non-overlapping implication, consequent checked in the next cycle.
`define B2D_ASSERT_NEXT(lbl, clk, off, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (off) (ante) |=> (cons)) \
        else $error("b2d check failed");

`endif

// ----- rtl/b2d_pkg.sv -----
// Shared types, constants and digit correction for the decimal digit unit.
`default_nettype none

package b2d_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int MAX_DIGITS_DEF = 10;
    localparam int BITS_PER_STAGE = 4;

    typedef logic [3:0] t_digit;

    localparam t_digit DIGIT_FIVE  = 4'd5;
    localparam t_digit DIGIT_THREE = 4'd3;

    // add-3 correction applied before each doubling
    function automatic t_digit adj(input t_digit d);
        return (d >= DIGIT_FIVE) ? t_digit'(d + DIGIT_THREE) : d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/b2d_dabble_stage.sv -----
// One register stage of the shift-and-add-3 conversion pipeline.
`default_nettype none

module b2d_dabble_stage #(
    parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF,
    parameter int STEPS      = b2d_pkg::BITS_PER_STAGE
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_vld,
    output logic                         o_rdy,
    input  wire logic [VALUE_BITS-1:0]   i_bin,
    input  wire logic [4*MAX_DIGITS-1:0] i_bcd,
    input  wire logic                    i_ovf,
    output logic                         o_vld,
    input  wire logic                    i_rdy,
    output logic [VALUE_BITS-1:0]        o_bin,
    output logic [4*MAX_DIGITS-1:0]      o_bcd,
    output logic                         o_ovf
);

    localparam int BCD_W = 4 * MAX_DIGITS;

    logic                  r_vld;
    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic                  r_ovf;

    logic [VALUE_BITS-1:0] n_bin;
    logic [BCD_W-1:0]      n_bcd;
    logic                  n_ovf;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        n_bin = i_bin;
        n_bcd = i_bcd;
        n_ovf = i_ovf;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                n_bcd[4*d +: 4] = b2d_pkg::adj(n_bcd[4*d +: 4]);
            end
            // carry out of the top digit: value no longer fits
            n_ovf = n_ovf | n_bcd[BCD_W-1];
            n_bcd = {n_bcd[BCD_W-2:0], n_bin[VALUE_BITS-1]};
            n_bin = {n_bin[VALUE_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
            r_ovf <= n_ovf;
        end
    end

    assign o_vld = r_vld;
    assign o_bin = r_bin;
    assign o_bcd = r_bcd;
    assign o_ovf = r_ovf;

endmodule

`default_nettype wire

// ----- rtl/binary_to_decimal_digits_unit.sv -----
// Top level: binary to decimal digit stream, pipelined conversion and digit serializer.
//
//  channel | dir | tdata (low bit up)             | tuser | tlast
//  s       | in  | value [VALUE_BITS-1:0], zeros  | -     | -
//  m       | out | digit [3:0], zeros             | -     | last digit
//
// Conversion runs through ceil(VALUE_BITS/4) register stages (eight stages at 31 bits), four
// bits per stage but the first, which takes the rest; a new value may enter every cycle while
// stages are free. The serializer gives one digit per cycle while m is ready, so an item gives
// as many digits as it has (1 to MAX_DIGITS) on the output.
// Reset (i_rst_n low, synchronous) clears all valid bits. Stalls on m back up stage by stage.
`default_nettype none

module binary_to_decimal_digits_unit #(
    parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     i_s_tdata,   // value, zero pad
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [7:0]                               o_m_tdata,   // digit, zero pad
    output logic                                     o_m_tlast
);

    localparam int BPS    = b2d_pkg::BITS_PER_STAGE;
    localparam int NSTG   = (VALUE_BITS + BPS - 1) / BPS;
    localparam int FIRST  = VALUE_BITS - (NSTG - 1) * BPS;
    localparam int BCD_W  = 4 * MAX_DIGITS;
    localparam int IDX_W  = $clog2(MAX_DIGITS);

    logic                  w_vld [NSTG+1];
    logic                  w_rdy [NSTG+1];
    logic [VALUE_BITS-1:0] w_bin [NSTG+1];
    logic [BCD_W-1:0]      w_bcd [NSTG+1];
    logic                  w_ovf [NSTG+1];

    logic                  r_s_vld;
    logic [BCD_W-1:0]      r_s_bcd;
    logic [IDX_W-1:0]      r_s_idx;

    logic [IDX_W-1:0]      w_top;
    logic                  w_s_last;
    logic                  w_ser_rdy;
    logic                  w_load;

    assign w_vld[0]   = i_s_tvalid;
    assign w_bin[0]   = i_s_tdata[VALUE_BITS-1:0];
    assign w_bcd[0]   = '0;
    assign w_ovf[0]   = 1'b0;
    assign o_s_tready = w_rdy[0];

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        b2d_dabble_stage #(
            .VALUE_BITS (VALUE_BITS),
            .MAX_DIGITS (MAX_DIGITS),
            .STEPS      ((k == 0) ? FIRST : BPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[k]),
            .o_rdy   (w_rdy[k]),
            .i_bin   (w_bin[k]),
            .i_bcd   (w_bcd[k]),
            .i_ovf   (w_ovf[k]),
            .o_vld   (w_vld[k+1]),
            .i_rdy   (w_rdy[k+1]),
            .o_bin   (w_bin[k+1]),
            .o_bcd   (w_bcd[k+1]),
            .o_ovf   (w_ovf[k+1])
        );
    end

    // most significant nonzero digit, zero maps to index 0
    always_comb begin
        w_top = '0;
        for (int d = 1; d < MAX_DIGITS; d++) begin
            if (w_bcd[NSTG][4*d +: 4] != 4'd0) begin
                w_top = IDX_W'(d);
            end
        end
    end

    assign w_s_last     = (r_s_idx == '0);
    assign w_ser_rdy    = !r_s_vld || (i_m_tready && w_s_last);
    assign w_rdy[NSTG]  = w_ser_rdy;
    assign w_load       = w_ser_rdy && w_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (w_ser_rdy) begin
            r_s_vld <= w_vld[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s_bcd <= w_bcd[NSTG];
            r_s_idx <= w_ovf[NSTG] ? IDX_W'(MAX_DIGITS - 1) : w_top;
        end else if (r_s_vld && i_m_tready && !w_s_last) begin
            r_s_idx <= r_s_idx - IDX_W'(1);
        end
    end

    assign o_m_tvalid = r_s_vld;
    assign o_m_tdata  = {4'd0, r_s_bcd[4*r_s_idx +: 4]};
    assign o_m_tlast  = w_s_last;

endmodule

`default_nettype wire

// ----- rtl/b2d_checker.sv -----
// Port-level checker for the decimal digit unit, bound to the top level.
`default_nettype none
`include "binary_to_decimal_digits_unit_macros.svh"

module b2d_checker #(
    parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tvalid,
    input wire logic                            o_s_tready,
    input wire logic [((VALUE_BITS+7)/8)*8-1:0] i_s_tdata,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [7:0]                      o_m_tdata,
    input wire logic                            o_m_tlast
);

    logic [7:0] r_open;
    logic       w_in_xfer;
    logic       w_end_xfer;

    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_end_xfer = o_m_tvalid && i_m_tready && o_m_tlast;

    // items taken in whose run has not ended yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + {7'd0, w_in_xfer} - {7'd0, w_end_xfer};
        end
    end

    `B2D_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b0, !i_rst_n, !o_m_tvalid)
    `B2D_ASSERT_NOW(a_digit_range, i_clk, !i_rst_n, o_m_tvalid, o_m_tdata <= 8'd9)
    `B2D_ASSERT_NOW(a_no_orphan, i_clk, !i_rst_n, o_m_tvalid, r_open != 8'd0)
    `B2D_ASSERT_NEXT(a_hold, i_clk, !i_rst_n, o_m_tvalid && !i_m_tready,
                     o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
    `B2D_ASSERT_NEXT(a_in_hold, i_clk, !i_rst_n, i_s_tvalid && !o_s_tready,
                     i_s_tvalid && $stable(i_s_tdata))

endmodule

bind binary_to_decimal_digits_unit b2d_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_b2d_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
